@@ design/nlcc_pkg.sv @@
package nlcc_pkg;

	// APB address: bit 2 selects the register index, the low bits are byte lanes
	localparam int ADDR_W = 3;

	localparam logic [0:0] REG_ENABLED = 1'b0;

	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_NUL  = 8'h00;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_GGA  = 2'd1,
		KIND_RMC  = 2'd2,
		KIND_VTG  = 2'd3
	} kind_t;

	typedef struct packed {
		logic       accepted;
		logic       checksum_ok;
		logic       star_found;
		kind_t      sentence_kind;
		logic [7:0] computed_sum;
		logic [7:0] received_sum;
		logic [6:0] line_length;
	} result_t;

endpackage

@@ design/nlcc_intf.sv @@
interface nlcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface nlcc_result_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic       checksum_ok;
	logic       star_found;
	logic [1:0] sentence_kind;
	logic [7:0] computed_sum;
	logic [7:0] received_sum;
	logic [6:0] line_length;

	modport source (
		output valid, output accepted, output checksum_ok, output star_found,
		output sentence_kind, output computed_sum, output received_sum,
		output line_length, input ready
	);
	modport sink (
		input valid, input accepted, input checksum_ok, input star_found,
		input sentence_kind, input computed_sum, input received_sum,
		input line_length, output ready
	);
endinterface

@@ design/nlcc_line.sv @@
module nlcc_line #(
	parameter int MAX_LINE = 127
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  logic              enabled,
	output logic              emit,
	output nlcc_pkg::result_t result
);
	import nlcc_pkg::*;

	localparam int PW = $clog2(MAX_LINE);
	localparam int LW = PW + 1;

	logic [PW-1:0] pos_q;
	logic [7:0]    xor_q, xor_d;
	logic          star_q, star_d;
	logic          xstop_q, xstop_d;
	logic [1:0]    hcnt_q, hcnt_d;
	logic [7:0]    hval_q, hval_d;
	logic          hbad_q, hbad_d;
	logic          hclosed_q, hclosed_d;
	logic [2:0]    pfx_q, pfx_d;
	logic          zero_q, zero_d;

	logic          term, full;
	logic [LW-1:0] pos_inc;
	logic [4:0]    hx;

	logic          s_star, s_bad;
	logic [1:0]    s_cnt;
	logic [7:0]    s_hval, s_xor, rx_sum;
	logic [2:0]    s_pfx;
	logic [LW-1:0] s_len;
	logic          hex_ok, sum_ok;
	kind_t         kind;

	function automatic logic [7:0] prefix_char(input logic [1:0] k, input logic [2:0] i);
		logic [7:0] c;
		c = 8'h00;
		case (i)
			3'd0: c = 8'h24; // '$'
			3'd1: c = 8'h47; // 'G'
			3'd2: c = 8'h50; // 'P'
			3'd3: c = (k == 2'd0) ? 8'h47 : (k == 2'd1) ? 8'h52 : 8'h56; // G R V
			3'd4: c = (k == 2'd0) ? 8'h47 : (k == 2'd1) ? 8'h4D : 8'h54; // G M T
			3'd5: c = (k == 2'd0) ? 8'h41 : (k == 2'd1) ? 8'h43 : 8'h47; // A C G
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// {valid, nibble}
	function automatic logic [4:0] hex_of(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39)
			r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h41 && b <= 8'h46)
			r = {1'b1, 4'(b - 8'h37)};
		else if (b >= 8'h61 && b <= 8'h66)
			r = {1'b1, 4'(b - 8'h57)};
		return r;
	endfunction

	always_comb begin
		term      = (rx_byte == CH_CR) || (rx_byte == CH_LF);
		pos_inc   = {1'b0, pos_q} + LW'(1);
		xor_d     = xor_q;
		star_d    = star_q;
		xstop_d   = xstop_q;
		hcnt_d    = hcnt_q;
		hval_d    = hval_q;
		hbad_d    = hbad_q;
		hclosed_d = hclosed_q;
		pfx_d     = pfx_q;
		zero_d    = zero_q;
		hx        = hex_of(rx_byte);

		if (pos_q < PW'(6)) begin
			for (int k = 0; k < 3; k++) begin
				if (rx_byte != prefix_char(2'(k), pos_q[2:0]))
					pfx_d[k] = 1'b0;
			end
		end

		if (!zero_q) begin
			if (rx_byte == CH_NUL) begin
				zero_d = 1'b1;
			end else begin
				// digits after the star, checked against the star state before this byte
				if (star_q && !hclosed_q) begin
					if (hx[4]) begin
						hval_d = {hval_q[3:0], hx[3:0]};
						hcnt_d = hcnt_q + 2'd1;
						if (hcnt_q != 2'd0)
							hclosed_d = 1'b1;
					end else begin
						if (hcnt_q == 2'd0)
							hbad_d = 1'b1;
						hclosed_d = 1'b1;
					end
				end
				if (rx_byte == CH_STAR)
					star_d = 1'b1;
				if (pos_q != '0 && !xstop_q) begin
					if (rx_byte == CH_STAR)
						xstop_d = 1'b1;
					else
						xor_d = xor_q ^ rx_byte;
				end
			end
		end

		full = pos_inc >= LW'(MAX_LINE);
		emit = term ? (pos_q != '0) : full;

		// CR/LF reports the line as it stood; a full line includes this byte
		s_star = term ? star_q : star_d;
		s_bad  = term ? hbad_q : hbad_d;
		s_cnt  = term ? hcnt_q : hcnt_d;
		s_hval = term ? hval_q : hval_d;
		s_xor  = term ? xor_q : xor_d;
		s_pfx  = term ? pfx_q : pfx_d;
		s_len  = term ? {1'b0, pos_q} : pos_inc;

		hex_ok = s_star && !s_bad && (s_cnt != 2'd0);
		rx_sum = hex_ok ? s_hval : 8'h00;
		sum_ok = hex_ok && (rx_sum == s_xor);

		kind = KIND_NONE;
		if (s_len >= LW'(6)) begin
			if (s_pfx[0])
				kind = KIND_GGA;
			else if (s_pfx[1])
				kind = KIND_RMC;
			else if (s_pfx[2])
				kind = KIND_VTG;
		end

		result.accepted      = enabled && s_star && sum_ok && (kind != KIND_NONE);
		result.checksum_ok   = sum_ok;
		result.star_found    = s_star;
		result.sentence_kind = kind;
		result.computed_sum  = s_xor;
		result.received_sum  = rx_sum;
		result.line_length   = 7'(s_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			xor_q     <= '0;
			star_q    <= 1'b0;
			xstop_q   <= 1'b0;
			hcnt_q    <= '0;
			hval_q    <= '0;
			hbad_q    <= 1'b0;
			hclosed_q <= 1'b0;
			pfx_q     <= '1;
			zero_q    <= 1'b0;
		end else if (step) begin
			if (term || full) begin
				pos_q     <= '0;
				xor_q     <= '0;
				star_q    <= 1'b0;
				xstop_q   <= 1'b0;
				hcnt_q    <= '0;
				hval_q    <= '0;
				hbad_q    <= 1'b0;
				hclosed_q <= 1'b0;
				pfx_q     <= '1;
				zero_q    <= 1'b0;
			end else begin
				pos_q     <= pos_inc[PW-1:0];
				xor_q     <= xor_d;
				star_q    <= star_d;
				xstop_q   <= xstop_d;
				hcnt_q    <= hcnt_d;
				hval_q    <= hval_d;
				hbad_q    <= hbad_d;
				hclosed_q <= hclosed_d;
				pfx_q     <= pfx_d;
				zero_q    <= zero_d;
			end
		end
	end

endmodule

@@ design/nmea_line_checksum_classifier.sv @@
// Channel   Role    Handshake      Payload
// rx        sink    valid/ready    rx_byte
// result    source  valid/ready    accepted, checksum_ok, star_found, sentence_kind,
//                                  computed_sum, received_sum, line_length
// apb       slave   psel/penable   enabled at byte address 0
//
// One byte per cycle while the result is not stalled: a byte sits in the input
// register, then the line state updates and any result loads the output register
// in the same cycle. A stalled result holds the byte in the input register;
// rx.ready drops only while both registers are full. arst_n clears line state,
// enabled and valids.
module nmea_line_checksum_classifier #(
	parameter int MAX_LINE = 127
) (
	input  logic                         clk,
	input  logic                         arst_n,
	nlcc_byte_if.sink                    rx,
	nlcc_result_if.source                result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [nlcc_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import nlcc_pkg::*;

	logic       enabled_q;
	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       res_valid_q;
	result_t    res_q;
	result_t    line_res;
	logic       line_emit;
	logic       advance;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ENABLED) ? {31'd0, enabled_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			enabled_q <= 1'b0;
		else if (psel && penable && pwrite && paddr[2] == REG_ENABLED)
			enabled_q <= pwdata[0];
	end

	assign advance  = valid_s1 && (!res_valid_q || result.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (rx.ready)
			valid_s1 <= rx.valid;
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.rx_byte;
	end

	nlcc_line #(.MAX_LINE(MAX_LINE)) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.enabled (enabled_q),
		.emit    (line_emit),
		.result  (line_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance)
			res_valid_q <= line_emit;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && line_emit)
			res_q <= line_res;
	end

	assign result.valid         = res_valid_q;
	assign result.accepted      = res_q.accepted;
	assign result.checksum_ok   = res_q.checksum_ok;
	assign result.star_found    = res_q.star_found;
	assign result.sentence_kind = res_q.sentence_kind;
	assign result.computed_sum  = res_q.computed_sum;
	assign result.received_sum  = res_q.received_sum;
	assign result.line_length   = res_q.line_length;

endmodule
